// ===== src/mfek_pkg.sv =====
`default_nettype none
package mfek_pkg;

    localparam int MAX_VERTICES  = 64;
    localparam int CAPACITY_BITS = 16;
    localparam int VERT_BITS     = $clog2(MAX_VERTICES);
    localparam int ADDR_BITS     = 2 * VERT_BITS;
    localparam int MAT_DEPTH     = MAX_VERTICES * MAX_VERTICES;
    localparam int RES_BITS      = CAPACITY_BITS + 1;
    localparam int FLOW_BITS     = 22;
    localparam int CNT_BITS      = 7;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_BFS_INIT,
        ST_POP,
        ST_POP_WAIT,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_AUG_INIT,
        ST_AUG_RD,
        ST_AUG_WAIT,
        ST_AUG_FWD,
        ST_AUG_REV_WAIT,
        ST_AUG_REV,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic load_edge;
        logic bfs_init;
        logic pop_read;
        logic pop_take;
        logic scan_read;
        logic scan_take;
        logic aug_init;
        logic aug_read_fwd;
        logic aug_write_fwd;
        logic aug_read_rev;
        logic aug_write_rev;
        logic finish;
    } cmd_t;

    // Status returned from the datapath.
    typedef struct packed {
        logic clear_last;
        logic queue_empty;
        logic sink_found;
        logic scan_last;
        logic aug_at_source;
    } stat_t;

endpackage
`default_nettype wire

// ===== src/mfek_ram.sv =====
`default_nettype none
module mfek_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== src/mfek_datapath.sv =====
`default_nettype none
module mfek_datapath
    import mfek_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    output stat_t                         stat,
    input  wire logic [CNT_BITS-1:0]      vertex_count,
    input  wire logic [VERT_BITS-1:0]     edge_from,
    input  wire logic [VERT_BITS-1:0]     edge_to,
    input  wire logic [CAPACITY_BITS-1:0] edge_capacity,
    output logic      [FLOW_BITS-1:0]     flow_out
);

    logic [VERT_BITS-1:0] sink;
    logic [CNT_BITS-1:0]  n_sat;

    always_comb
    begin
        n_sat = vertex_count;
        if (vertex_count < CNT_BITS'(2))
        begin
            n_sat = CNT_BITS'(2);
        end
        else if (vertex_count > CNT_BITS'(MAX_VERTICES))
        begin
            n_sat = CNT_BITS'(MAX_VERTICES);
        end
        sink = VERT_BITS'(n_sat - CNT_BITS'(1));
    end

    // Residual matrix memory.
    logic                 m_we;
    logic [ADDR_BITS-1:0] m_waddr, m_raddr;
    logic [RES_BITS-1:0]  m_wdata, m_rdata;

    mfek_ram #(.WIDTH(RES_BITS), .DEPTH(MAT_DEPTH)) u_matrix (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    // Predecessor, bottleneck and queue memories.
    logic                 p_we;
    logic [VERT_BITS-1:0] p_raddr, p_rdata;
    logic                 b_we;
    logic [VERT_BITS-1:0] b_waddr, b_raddr;
    logic [RES_BITS-1:0]  b_wdata, b_rdata;
    logic                 q_we;
    logic [VERT_BITS-1:0] q_raddr, q_rdata;

    logic [ADDR_BITS-1:0] clr_reg, clr_next;
    logic [MAX_VERTICES-1:0] vis_reg, vis_next;
    logic [CNT_BITS-1:0]  head_reg, head_next, tail_reg, tail_next;
    logic [VERT_BITS-1:0] u_reg, u_next, w_reg, w_next;
    logic [CNT_BITS-1:0]  scan_reg, scan_next;
    logic                 u_src_reg, u_src_next;
    logic [RES_BITS-1:0]  bot_reg, bot_next;
    logic [RES_BITS-1:0]  ub_reg, ub_next;
    logic [FLOW_BITS-1:0] flow_reg, flow_next;
    logic [VERT_BITS-1:0] scan_w;
    logic                 take;
    logic [RES_BITS-1:0]  cand;

    mfek_ram #(.WIDTH(VERT_BITS), .DEPTH(MAX_VERTICES)) u_pred (
        .clk(clk), .we(p_we), .waddr(scan_w), .wdata(u_reg),
        .raddr(p_raddr), .rdata(p_rdata)
    );
    mfek_ram #(.WIDTH(RES_BITS), .DEPTH(MAX_VERTICES)) u_bott (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );
    mfek_ram #(.WIDTH(VERT_BITS), .DEPTH(MAX_VERTICES)) u_queue (
        .clk(clk), .we(q_we), .waddr(tail_reg[VERT_BITS-1:0]), .wdata(scan_w),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    // The scanned column trails the read, as the RAM output is registered, so the
    // first scan cycle of a vertex carries no column yet.
    assign scan_w = VERT_BITS'(scan_reg - CNT_BITS'(1));
    assign take   = cmd.scan_take && (scan_reg != '0) && !vis_reg[scan_w] &&
                    (m_rdata != '0);
    assign cand   = (!u_src_reg && ub_reg < m_rdata) ? ub_reg : m_rdata;

    always_comb
    begin
        clr_next   = clr_reg;
        vis_next   = vis_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        u_next     = u_reg;
        w_next     = w_reg;
        scan_next  = scan_reg;
        u_src_next = u_src_reg;
        bot_next   = bot_reg;
        ub_next    = ub_reg;
        flow_next  = flow_reg;
        m_we       = 1'b0;
        m_waddr    = {edge_from, edge_to};
        m_wdata    = RES_BITS'(edge_capacity);
        m_raddr    = {u_reg, scan_reg[VERT_BITS-1:0]};
        p_we       = take;
        p_raddr    = w_reg;
        b_we       = take;
        b_waddr    = scan_w;
        b_wdata    = cand;
        b_raddr    = u_next;
        q_we       = take;
        q_raddr    = head_reg[VERT_BITS-1:0];

        if (cmd.clear_step)
        begin
            m_we     = 1'b1;
            m_waddr  = clr_reg;
            m_wdata  = '0;
            clr_next = clr_reg + ADDR_BITS'(1);
        end
        if (cmd.load_edge)
        begin
            m_we = 1'b1;
        end
        if (cmd.bfs_init)
        begin
            vis_next    = '0;
            vis_next[0] = 1'b1;
            head_next   = '0;
            tail_next   = '0;
            // The source becomes the current vertex directly, without passing through the queue.
            u_next      = '0;
            u_src_next  = 1'b1;
            scan_next   = '0;
            head_next   = CNT_BITS'(1);
            tail_next   = CNT_BITS'(1);
        end
        if (cmd.pop_take)
        begin
            u_next     = q_rdata;
            u_src_next = 1'b0;
            head_next  = head_reg + CNT_BITS'(1);
            scan_next  = '0;
        end
        if (cmd.pop_read)
        begin
            b_raddr = q_rdata;
        end
        if (cmd.scan_read)
        begin
            scan_next = scan_reg + CNT_BITS'(1);
        end
        if (cmd.pop_take)
        begin
            ub_next = b_rdata;
        end
        if (take)
        begin
            vis_next[scan_w] = 1'b1;
            tail_next        = tail_reg + CNT_BITS'(1);
            if (scan_w == sink)
            begin
                bot_next = cand;
            end
        end
        if (cmd.aug_init)
        begin
            flow_next = flow_reg + FLOW_BITS'(bot_reg);
            w_next    = sink;
        end
        if (cmd.aug_read_fwd)
        begin
            m_raddr = {p_rdata, w_reg};
        end
        if (cmd.aug_write_fwd)
        begin
            m_we    = 1'b1;
            m_waddr = {p_rdata, w_reg};
            m_wdata = m_rdata - bot_reg;
            m_raddr = {w_reg, p_rdata};
        end
        if (cmd.aug_read_rev)
        begin
            m_raddr = {w_reg, p_rdata};
        end
        if (cmd.aug_write_rev)
        begin
            m_we    = 1'b1;
            m_waddr = {w_reg, p_rdata};
            m_wdata = m_rdata + bot_reg;
            w_next  = p_rdata;
        end
        if (cmd.finish)
        begin
            flow_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            vis_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            scan_reg  <= '0;
            u_src_reg <= 1'b0;
            flow_reg  <= '0;
        end
        else
        begin
            clr_reg   <= clr_next;
            vis_reg   <= vis_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            scan_reg  <= scan_next;
            u_src_reg <= u_src_next;
            flow_reg  <= flow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg   <= u_next;
        w_reg   <= w_next;
        bot_reg <= bot_next;
        ub_reg  <= ub_next;
    end

    assign stat.clear_last    = (clr_reg == '1);
    assign stat.queue_empty   = (head_reg == tail_reg);
    assign stat.sink_found    = vis_reg[sink];
    assign stat.scan_last     = (scan_reg == n_sat);
    assign stat.aug_at_source = (w_reg == '0);
    assign flow_out           = flow_reg;

endmodule
`default_nettype wire

// ===== src/mfek_ctrl.sv =====
`default_nettype none
module mfek_ctrl
    import mfek_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire logic  last_edge,
    output logic       out_valid,
    input  wire logic  out_stall,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_edge = 1'b1;
                    if (last_edge)
                    begin
                        state_next = ST_BFS_INIT;
                    end
                end
            end
            ST_BFS_INIT:
            begin
                cmd.bfs_init = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_POP:
            begin
                if (stat.sink_found)
                begin
                    state_next = ST_AUG_INIT;
                end
                else if (stat.queue_empty)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                // Queue data is valid here; the bottleneck read is issued here and taken in ST_SCAN_WAIT.
                cmd.pop_read = 1'b1;
                state_next   = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT:
            begin
                cmd.pop_take = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_take = 1'b1;
                if (stat.sink_found)
                begin
                    state_next = ST_AUG_INIT;
                end
                else if (stat.scan_last)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.scan_read = 1'b1;
                end
            end
            ST_AUG_INIT:
            begin
                cmd.aug_init = 1'b1;
                state_next   = ST_AUG_RD;
            end
            ST_AUG_RD:
            begin
                if (stat.aug_at_source)
                begin
                    state_next = ST_BFS_INIT;
                end
                else
                begin
                    state_next = ST_AUG_WAIT;
                end
            end
            ST_AUG_WAIT:
            begin
                cmd.aug_read_fwd = 1'b1;
                state_next       = ST_AUG_FWD;
            end
            ST_AUG_FWD:
            begin
                cmd.aug_write_fwd = 1'b1;
                state_next        = ST_AUG_REV_WAIT;
            end
            ST_AUG_REV_WAIT:
            begin
                cmd.aug_read_rev = 1'b1;
                state_next       = ST_AUG_REV;
            end
            ST_AUG_REV:
            begin
                cmd.aug_write_rev = 1'b1;
                state_next        = ST_AUG_RD;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/max_flow_edmonds_karp_core.sv =====
`default_nettype none
// Edmonds-Karp maximum flow. Edges are taken one per cycle, while in_stall
// is low, into a 64x64 residual-capacity RAM; a later edge with the same
// endpoints replaces the earlier one. Vertex 0 is the source, vertex_count-1
// the sink. After the edge marked last_edge, a sequencer runs breadth-first
// searches and augments until no path remains, then presents max_flow. Each
// vertex popped makes one residual RAM read per column, and each path edge
// augmented reads and writes its forward, then its reverse residual. After the
// result is taken, and after reset, the matrix is cleared and no request is taken.
module max_flow_edmonds_karp_core
    import mfek_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CNT_BITS-1:0]      cfg_wdata,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [VERT_BITS-1:0]     edge_from,
    input  wire logic [VERT_BITS-1:0]     edge_to,
    input  wire logic [CAPACITY_BITS-1:0] edge_capacity,
    input  wire logic                     last_edge,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic      [FLOW_BITS-1:0]     max_flow
);

    logic [CNT_BITS-1:0] vcount_reg;
    cmd_t  cmd;
    stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= CNT_BITS'(MAX_VERTICES);
        end
        else if (cfg_we)
        begin
            vcount_reg <= cfg_wdata;
        end
    end

    mfek_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .last_edge (last_edge),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    mfek_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .vertex_count  (vcount_reg),
        .edge_from     (edge_from),
        .edge_to       (edge_to),
        .edge_capacity (edge_capacity),
        .flow_out      (max_flow)
    );

endmodule
`default_nettype wire

// ===== src/mfek_checker.sv =====
`default_nettype none
module mfek_checker
    import mfek_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_stall,
    input wire logic                 last_edge,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic [FLOW_BITS-1:0] max_flow
);

    // A result never shows while requests are being taken.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result while taking requests");

    // After the last edge is taken the block stops taking requests.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_edge) |=> in_stall)
        else $error("request taken after last edge");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(max_flow)))
        else $error("stalled result changed");

    // Once taken, the result drops.
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("result repeated");

endmodule

bind max_flow_edmonds_karp_core mfek_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_edge (last_edge),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .max_flow  (max_flow)
);
`default_nettype wire
